FILE: rtl/http_chunked_decoder_unit_macros.svh
// Assertion macros used by the checker file of the chunked decoder.
`ifndef HTTP_CHUNKED_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

   // Completion status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
   localparam logic [1:0] STATUS_NO_CRLF   = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // Most hex digits accepted in one chunk size (range 1 to 15).
   localparam int unsigned MAX_SIZE_DIGITS = 8;

   // One result word as it travels from the decoder to the output buffer.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       finished;
      logic [1:0] status;
   } hcd_result_type;

endpackage

FILE: rtl/http_chunked_decoder_unit.sv
`timescale 1ns / 1ps

// HTTP chunked transfer decoder. Encoded body bytes enter one word per cycle on the
// req_ channel while req_ready is high; each chunk is a run of hex size digits (at
// most eight), CR LF, that many payload bytes and two trailing bytes that are
// skipped unchecked. Payload bytes come out on the rsp_ channel with rsp_byte_valid
// set. A size of a single '0' ends the stream with success; too many digits, a
// missing CR LF or an empty size end it with an error status. The last word of a
// stream carries rsp_finished, and after that the decoder drops bytes up to and
// including the next one marked end_of_stream. A byte marked end_of_stream always
// closes the stream. Chunk extensions and trailers are not supported. The decoder
// sustains one byte per cycle while the output buffer has space: the chunk state
// update is a single combinational step per byte. A byte passes through the input
// register and then the output buffer before its result is offered.
module http_chunked_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_finished,
   output logic [1:0] rsp_status
);

   // Input register holding the next byte to be decoded.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   logic                   buf_space;
   logic                   step_fire;
   logic                   accept;
   hcd_pkg::hcd_result_type step_result;
   logic                   step_result_valid;
   hcd_pkg::hcd_result_type rsp_data;

   // The held byte is decoded whenever the output buffer can take its word.
   assign step_fire   = in_valid_ff && buf_space;
   assign req_ready   = !in_valid_ff || step_fire;
   assign accept      = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   hcd_step u_step (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_fire),
      .in_byte       (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .result        (step_result),
      .result_valid  (step_result_valid)
   );

   // Two-entry buffer so the decoder keeps running while a word waits.
   hcd_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (step_fire && step_result_valid),
      .push_data (step_result),
      .space     (buf_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_byte_valid = rsp_data.byte_valid;
   assign rsp_finished   = rsp_data.finished;
   assign rsp_status     = rsp_data.status;

endmodule

FILE: rtl/hcd_step.sv
`timescale 1ns / 1ps

module hcd_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             in_byte,
   input  logic                   end_of_stream,
   output hcd_pkg::hcd_result_type result,
   output logic                   result_valid
);

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_LF    = 3'd1,
      PH_DATA  = 3'd2,
      PH_SKIP1 = 3'd3,
      PH_SKIP2 = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   phase_type   phase_ff, phase_in;
   logic [3:0]  digit_count_ff, digit_count_in;
   logic        single_zero_ff, single_zero_in;
   logic [31:0] remaining_ff, remaining_in;

   logic        is_hex;
   logic [3:0]  hex_val;
   logic        fin;
   logic [1:0]  status;
   logic        valid;
   logic        emit;
   logic        restart;
   logic [31:0] remaining_dec;

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [7:0] d;
      begin
         d = 8'h00;
         if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            hex_decode = {1'b1, d[3:0]};
         end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            hex_decode = {1'b1, d[3:0]};
         end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            hex_decode = {1'b1, d[3:0]};
         end else begin
            hex_decode = 5'b0_0000;
         end
      end
   endfunction

   assign {is_hex, hex_val} = hex_decode(in_byte);
   assign remaining_dec = remaining_ff - 32'd1;

   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      single_zero_in = single_zero_ff;
      remaining_in   = remaining_ff;
      fin            = 1'b0;
      status         = hcd_pkg::STATUS_OK;
      valid          = 1'b0;
      emit           = 1'b0;
      restart        = 1'b0;

      unique case (phase_ff)
         PH_SIZE: begin
            if (is_hex) begin
               if (digit_count_ff >= 4'(hcd_pkg::MAX_SIZE_DIGITS)) begin
                  fin    = 1'b1;
                  status = hcd_pkg::STATUS_TOO_LONG;
               end else begin
                  single_zero_in = (digit_count_ff == 4'd0) && (hex_val == 4'd0);
                  digit_count_in = digit_count_ff + 4'd1;
                  if (remaining_ff > 32'h0FFF_FFFF) begin
                     remaining_in = 32'hFFFF_FFFF;
                  end else begin
                     remaining_in = {remaining_ff[27:0], hex_val};
                  end
               end
            end else if (digit_count_ff == 4'd1 && single_zero_ff) begin
               fin = 1'b1;
            end else if (in_byte != CHAR_CR) begin
               fin    = 1'b1;
               status = hcd_pkg::STATUS_NO_CRLF;
            end else begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            if (in_byte != CHAR_LF) begin
               fin    = 1'b1;
               status = hcd_pkg::STATUS_NO_CRLF;
            end else if (digit_count_ff == 4'd0) begin
               fin    = 1'b1;
               status = hcd_pkg::STATUS_EMPTY;
            end else begin
               phase_in = (remaining_ff == 32'd0) ? PH_SKIP1 : PH_DATA;
            end
         end
         PH_DATA: begin
            valid        = 1'b1;
            remaining_in = remaining_dec;
            if (remaining_dec == 32'd0) begin
               phase_in = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            phase_in = PH_SKIP2;
         end
         PH_SKIP2: begin
            restart = 1'b1;
         end
         default: begin
            // Finished stream: swallow bytes up to the end-of-stream mark.
            restart = end_of_stream;
         end
      endcase

      if (phase_ff != PH_DONE) begin
         if (fin) begin
            emit = 1'b1;
            if (end_of_stream) begin
               restart = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end else if (end_of_stream) begin
            // Truncated input still closes the stream with success.
            fin     = 1'b1;
            status  = hcd_pkg::STATUS_OK;
            emit    = 1'b1;
            restart = 1'b1;
         end else begin
            emit = valid;
         end
      end

      if (restart) begin
         phase_in       = PH_SIZE;
         digit_count_in = 4'd0;
         single_zero_in = 1'b0;
         remaining_in   = 32'd0;
      end
   end

   assign result.out_byte   = valid ? in_byte : 8'h00;
   assign result.byte_valid = valid;
   assign result.finished   = fin;
   assign result.status     = fin ? status : hcd_pkg::STATUS_OK;
   assign result_valid      = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         digit_count_ff <= 4'd0;
         single_zero_ff <= 1'b0;
         remaining_ff   <= 32'd0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         single_zero_ff <= single_zero_in;
         remaining_ff   <= remaining_in;
      end
   end

endmodule

FILE: rtl/hcd_out_buffer.sv
`timescale 1ns / 1ps

module hcd_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hcd_pkg::hcd_result_type push_data,
   output logic                   space,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hcd_pkg::hcd_result_type rsp_data
);

   hcd_pkg::hcd_result_type entry_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic       tail;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   // A full buffer still takes a word in the cycle its head word leaves.
   assign space     = (count_ff != 2'd2) || rsp_ready;
   assign tail      = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail] <= push_data;
      end
   end

endmodule

FILE: rtl/hcd_checker.sv
`timescale 1ns / 1ps

`include "http_chunked_decoder_unit_macros.svh"

module hcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_finished,
   input logic [1:0] rsp_status
);

   // A stalled word stays offered.
   `HCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   // Every word is either a payload byte or the close of a stream.
   `HCD_ASSERT_SAME(a_rsp_content, clock, reset, rsp_valid, rsp_byte_valid || rsp_finished, "empty rsp word")
   // Non-payload words carry a zero byte.
   `HCD_ASSERT_SAME(a_rsp_byte_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_out_byte == 8'h00, "stray out byte")
   // Status is only meaningful on a closing word.
   `HCD_ASSERT_SAME(a_rsp_status_zero, clock, reset, rsp_valid && !rsp_finished, rsp_status == hcd_pkg::STATUS_OK, "stray status")
   // Nothing is offered right after reset.
   `HCD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind http_chunked_decoder_unit hcd_checker u_hcd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_byte_valid    (rsp_byte_valid),
   .rsp_finished      (rsp_finished),
   .rsp_status        (rsp_status)
);
